[rtl/note_duration_splitter_unit_assert.svh]
// assertion macros for the note duration splitter checker
// no dependencies; included by nds_checker.sv
`ifndef NOTE_DURATION_SPLITTER_UNIT_ASSERT_SVH
`define NOTE_DURATION_SPLITTER_UNIT_ASSERT_SVH

// same-cycle implication
`define NDS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("note duration splitter check failed");

// next-cycle implication
`define NDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("note duration splitter check failed");

`endif

[rtl/nds_pkg.sv]
// types, constants and helpers shared by the note duration splitter
// no dependencies
package nds_pkg;

    localparam int NUM_VALUES   = 10;
    localparam int DUR_W        = 32;
    localparam int TPQ_W        = 16;
    localparam int CNT_W        = 28;
    localparam int NV_W         = 4;
    localparam int LEFT_W       = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int BREVE_SHIFT  = 4;
    localparam int REM_W        = TPQ_W + BREVE_SHIFT;
    localparam int SMALL_W      = 2;
    localparam int QUANT_STAGES = DUR_W;
    localparam int BREVE_STAGES = DUR_W - BREVE_SHIFT;
    localparam int GREEDY_STEPS = NUM_VALUES - 1;
    localparam int QUARTER_IDX  = 4;

    localparam logic [NV_W-1:0]      NV_LAST     = NV_W'(NUM_VALUES - 1);
    localparam logic [CFG_IDX_W-1:0] CFG_TPQ     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd1;
    localparam logic [TPQ_W-1:0]     TPQ_RESET   = 16'd480;
    localparam logic [LEFT_W-1:0]    LEFT_MAX    = {LEFT_W{1'b1}};
    localparam logic [SMALL_W-1:0]   SMALL_ONE   = 2'd1;
    localparam logic [SMALL_W-1:0]   SMALL_TWO   = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [DUR_W-1:0] duration;
        logic [DUR_W-1:0] rem;
    } quant_stage_t;

    typedef struct packed {
        logic                    valid;
        logic [DUR_W-1:0]        qrem;
        logic [BREVE_STAGES-1:0] dividend;
        logic [BREVE_SHIFT-1:0]  low;
        logic [TPQ_W-1:0]        rem;
        logic [CNT_W-1:0]        quot;
    } breve_stage_t;

    typedef logic [NUM_VALUES-1:1][SMALL_W-1:0] small_cnt_t;

    typedef struct packed {
        logic             valid;
        logic [DUR_W-1:0] qrem;
        logic [CNT_W-1:0] breve_cnt;
        small_cnt_t       small_cnt;
        logic [REM_W-1:0] rem;
    } greedy_stage_t;

    // ticks of note value k, truncated
    function automatic logic [REM_W-1:0] note_ticks(input logic [TPQ_W-1:0] tpq, input int k);
        logic [REM_W-1:0] base;
        base = REM_W'(tpq);
        if (k <= QUARTER_IDX)
        begin
            return base << (QUARTER_IDX - k);
        end
        else
        begin
            return base >> (k - QUARTER_IDX);
        end
    endfunction

endpackage

[rtl/note_duration_splitter_unit.sv]
// note duration splitter top level: config registers, pipeline and result serializer
// depends on nds_pkg, nds_quant_pipe, nds_breve_pipe, nds_greedy_pipe, nds_serializer
//
// Each accepted duration yields ten result transactions, breve first and 128th last, on
// consecutive cycles while result_stall is low, so the sustained rate of durations is set by
// the single result port. A new duration may be accepted every cycle while the pipeline has
// room; on its way to the result port it passes 32 remainder stages for the quantum, one
// stage forming the quantized rest, 28 divider stages for the breve count and 9 stages for
// the smaller note values. Registers are written through the cfg port, which is always
// ready, and must only be written while the block is idle.
module note_duration_splitter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nds_pkg::DUR_W-1:0]         cfg_data,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [nds_pkg::DUR_W-1:0]         duration,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [nds_pkg::NV_W-1:0]          note_value,
    output logic [nds_pkg::CNT_W-1:0]         count,
    output logic [nds_pkg::DUR_W-1:0]         quant_remainder,
    output logic [nds_pkg::LEFT_W-1:0]        leftover,
    output logic                              last
);
    import nds_pkg::*;

    logic [TPQ_W-1:0] tpq_reg, tpq_next;
    logic [DUR_W-1:0] quantum_reg, quantum_next;
    logic             adv;
    logic             take;
    quant_stage_t     quant_out;
    breve_stage_t     breve_out;
    greedy_stage_t    greedy_out;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        tpq_next     = tpq_reg;
        quantum_next = quantum_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TPQ:     tpq_next     = cfg_data[TPQ_W-1:0];
                CFG_QUANTUM: quantum_next = cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpq_reg     <= TPQ_RESET;
            quantum_reg <= '0;
        end
        else
        begin
            tpq_reg     <= tpq_next;
            quantum_reg <= quantum_next;
        end
    end

    // whole pipeline advances unless the serializer refuses a finished item
    assign adv        = !greedy_out.valid || take;
    assign item_stall = !adv;

    nds_quant_pipe u_quant (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .quantum    (quantum_reg),
        .item_valid (item_valid),
        .duration   (duration),
        .out_stage  (quant_out)
    );

    nds_breve_pipe u_breve (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .tpq       (tpq_reg),
        .quantum   (quantum_reg),
        .in_stage  (quant_out),
        .out_stage (breve_out)
    );

    nds_greedy_pipe u_greedy (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .tpq       (tpq_reg),
        .in_stage  (breve_out),
        .out_stage (greedy_out)
    );

    nds_serializer u_ser (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_stage        (greedy_out),
        .take            (take),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .note_value      (note_value),
        .count           (count),
        .quant_remainder (quant_remainder),
        .leftover        (leftover),
        .last            (last)
    );

endmodule

[rtl/nds_quant_pipe.sv]
// restoring remainder pipeline, one bit per stage, for duration mod quantum
// depends on nds_pkg
module nds_quant_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic [nds_pkg::DUR_W-1:0]   quantum,
    input  logic                        item_valid,
    input  logic [nds_pkg::DUR_W-1:0]   duration,
    output nds_pkg::quant_stage_t       out_stage
);
    import nds_pkg::*;

    quant_stage_t stage_in   [QUANT_STAGES];
    quant_stage_t stage_next [QUANT_STAGES];
    quant_stage_t stage_reg  [QUANT_STAGES];

    for (genvar i = 0; i < QUANT_STAGES; i++)
    begin : g_stage
        if (i == 0)
        begin : g_first
            assign stage_in[i] = '{valid: item_valid, duration: duration, rem: '0};
        end
        else
        begin : g_rest
            assign stage_in[i] = stage_reg[i-1];
        end

        always_comb
        begin
            logic [DUR_W:0] trial;
            trial = {stage_in[i].rem, stage_in[i].duration[DUR_W-1-i]};
            stage_next[i] = stage_in[i];
            if (trial >= {1'b0, quantum})
            begin
                stage_next[i].rem = DUR_W'(trial - {1'b0, quantum});
            end
            else
            begin
                stage_next[i].rem = trial[DUR_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_reg[i] <= '0;
            end
            else if (adv)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign out_stage = stage_reg[QUANT_STAGES-1];

endmodule

[rtl/nds_breve_pipe.sv]
// quantized rest and breve count: restoring divider pipeline by ticks_per_quarter
// depends on nds_pkg
module nds_breve_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic [nds_pkg::TPQ_W-1:0]   tpq,
    input  logic [nds_pkg::DUR_W-1:0]   quantum,
    input  nds_pkg::quant_stage_t       in_stage,
    output nds_pkg::breve_stage_t       out_stage
);
    import nds_pkg::*;

    breve_stage_t entry_next;
    breve_stage_t entry_reg;
    breve_stage_t stage_in   [BREVE_STAGES];
    breve_stage_t stage_next [BREVE_STAGES];
    breve_stage_t stage_reg  [BREVE_STAGES];

    always_comb
    begin
        logic [DUR_W-1:0] qrem;
        logic [DUR_W-1:0] rest;
        qrem = (quantum == '0) ? '0 : in_stage.rem;
        rest = in_stage.duration - qrem;
        entry_next.valid    = in_stage.valid;
        entry_next.qrem     = qrem;
        entry_next.dividend = rest[DUR_W-1:BREVE_SHIFT];
        entry_next.low      = rest[BREVE_SHIFT-1:0];
        entry_next.rem      = '0;
        entry_next.quot     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (adv)
        begin
            entry_reg <= entry_next;
        end
    end

    for (genvar i = 0; i < BREVE_STAGES; i++)
    begin : g_stage
        if (i == 0)
        begin : g_first
            assign stage_in[i] = entry_reg;
        end
        else
        begin : g_rest
            assign stage_in[i] = stage_reg[i-1];
        end

        always_comb
        begin
            logic [TPQ_W:0] trial;
            trial = {stage_in[i].rem, stage_in[i].dividend[BREVE_STAGES-1-i]};
            stage_next[i] = stage_in[i];
            if (trial >= {1'b0, tpq})
            begin
                stage_next[i].rem  = TPQ_W'(trial - {1'b0, tpq});
                stage_next[i].quot = {stage_in[i].quot[CNT_W-2:0], 1'b1};
            end
            else
            begin
                stage_next[i].rem  = trial[TPQ_W-1:0];
                stage_next[i].quot = {stage_in[i].quot[CNT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_reg[i] <= '0;
            end
            else if (adv)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign out_stage = stage_reg[BREVE_STAGES-1];

endmodule

[rtl/nds_greedy_pipe.sv]
// greedy split of the sub-breve remainder, one note value per stage
// depends on nds_pkg
module nds_greedy_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic [nds_pkg::TPQ_W-1:0]   tpq,
    input  nds_pkg::breve_stage_t       in_stage,
    output nds_pkg::greedy_stage_t      out_stage
);
    import nds_pkg::*;

    greedy_stage_t entry;
    greedy_stage_t stage_in   [GREEDY_STEPS];
    greedy_stage_t stage_next [GREEDY_STEPS];
    greedy_stage_t stage_reg  [GREEDY_STEPS];

    // zero ticks per quarter: all counts zero, saturated rest as leftover
    always_comb
    begin
        logic [DUR_W-1:0]  rest;
        logic [LEFT_W-1:0] sat;
        logic              zero_tpq;
        rest     = {in_stage.dividend, in_stage.low};
        sat      = (rest > DUR_W'(LEFT_MAX)) ? LEFT_MAX : rest[LEFT_W-1:0];
        zero_tpq = (tpq == '0);
        entry.valid     = in_stage.valid;
        entry.qrem      = in_stage.qrem;
        entry.breve_cnt = zero_tpq ? '0 : in_stage.quot;
        entry.small_cnt = '0;
        entry.rem       = zero_tpq ? REM_W'(sat) : {in_stage.rem, in_stage.low};
    end

    for (genvar j = 0; j < GREEDY_STEPS; j++)
    begin : g_stage
        if (j == 0)
        begin : g_first
            assign stage_in[j] = entry;
        end
        else
        begin : g_rest
            assign stage_in[j] = stage_reg[j-1];
        end

        always_comb
        begin
            logic [REM_W-1:0] ticks;
            logic [REM_W:0]   twice;
            logic [REM_W-1:0] r;
            ticks = note_ticks(tpq, j + 1);
            twice = {ticks, 1'b0};
            r     = stage_in[j].rem;
            stage_next[j] = stage_in[j];
            stage_next[j].small_cnt[j+1] = '0;
            if (ticks != '0)
            begin
                if ({1'b0, r} >= twice)
                begin
                    stage_next[j].small_cnt[j+1] = SMALL_TWO;
                    stage_next[j].rem            = REM_W'({1'b0, r} - twice);
                end
                else if (r >= ticks)
                begin
                    stage_next[j].small_cnt[j+1] = SMALL_ONE;
                    stage_next[j].rem            = r - ticks;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_reg[j] <= '0;
            end
            else if (adv)
            begin
                stage_reg[j] <= stage_next[j];
            end
        end
    end

    assign out_stage = stage_reg[GREEDY_STEPS-1];

endmodule

[rtl/nds_serializer.sv]
// holds one split duration and emits its ten result transactions in order
// depends on nds_pkg
module nds_serializer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nds_pkg::greedy_stage_t       in_stage,
    output logic                         take,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [nds_pkg::NV_W-1:0]     note_value,
    output logic [nds_pkg::CNT_W-1:0]    count,
    output logic [nds_pkg::DUR_W-1:0]    quant_remainder,
    output logic [nds_pkg::LEFT_W-1:0]   leftover,
    output logic                         last
);
    import nds_pkg::*;

    logic          busy_reg, busy_next;
    logic [NV_W-1:0] idx_reg, idx_next;
    greedy_stage_t item_reg, item_next;
    logic          at_last;

    assign at_last = (idx_reg == NV_LAST);
    assign take    = !busy_reg || (at_last && !result_stall);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        item_next = item_reg;
        if (busy_reg && !result_stall)
        begin
            idx_next = idx_reg + NV_W'(1);
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (take && in_stage.valid)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            item_next = in_stage;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    always_comb
    begin
        if (idx_reg == '0)
        begin
            count = item_reg.breve_cnt;
        end
        else
        begin
            count = CNT_W'(item_reg.small_cnt[idx_reg]);
        end
    end

    assign result_valid    = busy_reg;
    assign note_value      = idx_reg;
    assign quant_remainder = item_reg.qrem;
    assign last            = at_last;
    assign leftover        = at_last ? item_reg.rem[LEFT_W-1:0] : '0;

endmodule

[rtl/nds_checker.sv]
// port-level checker for the note duration splitter, bound to the top level
// depends on nds_pkg and note_duration_splitter_unit_assert.svh
`include "note_duration_splitter_unit_assert.svh"

module nds_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             result_valid,
    input logic                             result_stall,
    input logic [nds_pkg::NV_W-1:0]         note_value,
    input logic [nds_pkg::CNT_W-1:0]        count,
    input logic [nds_pkg::DUR_W-1:0]        quant_remainder,
    input logic [nds_pkg::LEFT_W-1:0]       leftover,
    input logic                             last
);
    import nds_pkg::*;

    // stalled result transaction holds
    `NDS_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(note_value) && $stable(count))

    // results of one duration follow back to back in note order
    `NDS_ASSERT_NEXT(a_result_order, clk, rst_n, result_valid && !result_stall && !last, result_valid && (note_value == NV_W'($past(note_value) + 1'b1)) && $stable(quant_remainder))

    // last marks the 128th note only
    `NDS_ASSERT_IMPL(a_last_flag, clk, rst_n, result_valid, last == (note_value == NV_LAST))

    // leftover is only carried on the last result
    `NDS_ASSERT_IMPL(a_leftover_zero, clk, rst_n, result_valid && !last, leftover == '0)

endmodule

bind note_duration_splitter_unit nds_checker u_nds_checker (.*);
